// ----- hw/rtl/hmlpt_pkg.sv -----
// ----------------------------------------------------------------------------
// hmlpt_pkg: shared types and constants of the linear-probe hash map
// Request modes, slot state codes, slot entry layout, stream widths and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package hmlpt_pkg;

  // Request modes (carried in in_tuser)
  localparam logic [1:0] MODE_GET    = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_DEL    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Slot state codes
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int LIMIT_W = 6;
  localparam int USED_W  = 7;

  // Stream payload widths
  localparam int IN_DATA_W  = KEY_W + VALUE_W;
  localparam int OUT_BITS   = 1 + VALUE_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  // Home slot reduction: key bits consumed per step
  localparam int DIGIT_W     = 4;
  localparam int DIGIT_COUNT = KEY_W / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(DIGIT_COUNT);

  // One table entry as stored in the slot memory
  typedef struct packed {
    logic [1:0]         state;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_ISSUE,
    ST_PROBE,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;        // write one empty slot of the clearing pass
    logic load;         // take a request from the input channel
    logic mod_step;     // reduce one digit of the key hash
    logic probe_start;  // read the home slot
    logic probe_step;   // check one slot, read the next
    logic res_load;     // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;   // clearing pass at its last slot
    logic quick;        // request answered without a probe
    logic mod_bypass;   // home slot taken from low key bits directly
    logic mod_last;     // last digit of the reduction
    logic probe_done;   // checked slot ends the probe
    logic out_free;     // output register can take a result
  } sts_t;

endpackage

// ----- hw/rtl/hash_map_linear_probe_tombstone_top.sv -----
// ----------------------------------------------------------------------------
// hash_map_linear_probe_tombstone_top: open-addressing map with tombstones
// Usage:
//   in_*  : one request per handshake; in_tuser is the mode (get, set,
//           delete), in_tdata the key hash and the value to store.
//   out_* : one result per request, in request order.
//   cfg_* : write of the max_used limit; write only while the map is idle.
// The home slot is key_hash mod SLOT_COUNT, then linear probing with wrap,
// one slot checked per cycle through the single read port of the slot RAM.
// A request is accepted, reads its home slot, probes 1 to SLOT_COUNT slots
// until one decides and hands its result on. Requests answered without a
// probe (empty map, full map on set, unused mode) go from accept to hand-off.
// When SLOT_COUNT is not a power of two, a home slot reduction runs first.
// After reset a clearing pass empties every slot; no
// request is taken meanwhile, configuration writes are.
// The output register holds a result while out_tready is low; the next
// request is still accepted and runs until its result is ready to leave.
// ----------------------------------------------------------------------------
module hash_map_linear_probe_tombstone_top #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Request: tdata = key_hash[31:0], write_value[95:32]; tuser = mode[1:0]
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [hmlpt_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [hmlpt_pkg::MODE_W-1:0]          in_tuser,
  // Result: tdata = hit[0], read_value[64:1], status[65], zero pad[71:66]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [hmlpt_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Limit register write: cfg_data = max_used
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hmlpt_pkg::LIMIT_W-1:0]         cfg_data
);

  hmlpt_pkg::cmd_t cmd;
  hmlpt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  hmlpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hmlpt_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

`ifndef ASSERT_OFF
  // One request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  // A result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_tvalid || out_tready))
    else $error("result loaded over a waiting result");

  // Controller issues at most one command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.load, cmd.mod_step, cmd.probe_start,
              cmd.probe_step, cmd.res_load}))
    else $error("conflicting datapath commands");

  // No request taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !in_tready)
    else $error("request accepted during clearing pass");
`endif

endmodule

// ----- hw/rtl/hmlpt_ram.sv -----
// ----------------------------------------------------------------------------
// hmlpt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hmlpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/hmlpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// hmlpt_ctrl: request sequencer of the hash map
// Runs the clearing pass after reset, then steps each request through home
// slot reduction, probing (where needed) and hand-off by datapath commands.
// ----------------------------------------------------------------------------
module hmlpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  hmlpt_pkg::sts_t   sts,
  output hmlpt_pkg::cmd_t   cmd
);

  hmlpt_pkg::state_t state_r;
  hmlpt_pkg::state_t state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hmlpt_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hmlpt_pkg::ST_CLEAR: begin
        if (sts.clear_last) state_nxt = hmlpt_pkg::ST_IDLE;
      end
      hmlpt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          priority if (sts.quick)      state_nxt = hmlpt_pkg::ST_RESP;
          else if (sts.mod_bypass)     state_nxt = hmlpt_pkg::ST_ISSUE;
          else                         state_nxt = hmlpt_pkg::ST_MOD;
        end
      end
      hmlpt_pkg::ST_MOD: begin
        if (sts.mod_last) state_nxt = hmlpt_pkg::ST_ISSUE;
      end
      hmlpt_pkg::ST_ISSUE: begin
        state_nxt = hmlpt_pkg::ST_PROBE;
      end
      hmlpt_pkg::ST_PROBE: begin
        if (sts.probe_done) state_nxt = hmlpt_pkg::ST_RESP;
      end
      hmlpt_pkg::ST_RESP: begin
        if (sts.out_free) state_nxt = hmlpt_pkg::ST_IDLE;
      end
      default: state_nxt = hmlpt_pkg::ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      hmlpt_pkg::ST_CLEAR: cmd.clear = 1'b1;
      hmlpt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      hmlpt_pkg::ST_MOD:   cmd.mod_step    = 1'b1;
      hmlpt_pkg::ST_ISSUE: cmd.probe_start = 1'b1;
      hmlpt_pkg::ST_PROBE: cmd.probe_step  = 1'b1;
      hmlpt_pkg::ST_RESP:  cmd.res_load    = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hw/rtl/hmlpt_dp.sv -----
// ----------------------------------------------------------------------------
// hmlpt_dp: datapath of the hash map
// Request registers, home slot reduction, slot memory with probe evaluation,
// used count, limit register and the output register.
// ----------------------------------------------------------------------------
module hmlpt_dp #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hmlpt_pkg::cmd_t                       cmd,
  output hmlpt_pkg::sts_t                       sts,
  input  logic [hmlpt_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [hmlpt_pkg::MODE_W-1:0]          in_tuser,
  input  logic                                  cfg_valid,
  input  logic [hmlpt_pkg::LIMIT_W-1:0]         cfg_data,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic [hmlpt_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int REM_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [REM_W-1:0] MOD_N    = REM_W'(SLOT_COUNT);
  localparam bit IS_POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;

  // Request
  logic [hmlpt_pkg::MODE_W-1:0]  mode_r;
  logic [hmlpt_pkg::KEY_W-1:0]   key_r;
  logic [hmlpt_pkg::VALUE_W-1:0] wv_r;

  // Home slot reduction
  logic [hmlpt_pkg::KEY_W-1:0]       mod_key_r;
  logic [REM_W-1:0]                  mod_r;
  logic [REM_W-1:0]                  mod_nxt;
  logic [hmlpt_pkg::DIGIT_CNT_W-1:0] mod_cnt_r;
  logic [IDX_W-1:0]                  home;

  // Probe
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] n_r;
  logic             have_tomb_r;
  logic [IDX_W-1:0] tomb_r;
  logic [IDX_W-1:0] clr_r;

  // Table bookkeeping
  logic [hmlpt_pkg::USED_W-1:0]  used_count_r;
  logic [hmlpt_pkg::LIMIT_W-1:0] max_used_r;

  // Result, then output register
  logic                          res_hit_r;
  logic [hmlpt_pkg::VALUE_W-1:0] res_val_r;
  logic                          res_status_r;
  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [hmlpt_pkg::VALUE_W-1:0] out_val_r;
  logic                          out_status_r;

  // Memory ports
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  hmlpt_pkg::slot_t              ram_wdata;
  logic [IDX_W-1:0]              ram_raddr;
  logic [hmlpt_pkg::SLOT_W-1:0]  ram_rdata;
  hmlpt_pkg::slot_t              rd;

  // Probe evaluation
  logic             is_empty;
  logic             is_match;
  logic             is_tomb;
  logic             last_probe;
  logic             done;
  logic             pr_match;
  logic             pr_free;
  logic             fills_empty;
  logic [IDX_W-1:0] where;
  logic             finish;
  logic             need_write;

  // Quick answers at accept
  logic [hmlpt_pkg::MODE_W-1:0] in_mode;
  logic                         full;
  logic                         used_zero;
  logic                         quick_status;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    next_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign in_mode      = in_tuser;
  assign full         = used_count_r >= {1'b0, max_used_r};
  assign used_zero    = used_count_r == '0;
  assign quick_status = (in_mode == hmlpt_pkg::MODE_SET) && full;

  // Request registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      key_r  <= in_tdata[hmlpt_pkg::KEY_W-1:0];
      wv_r   <= in_tdata[hmlpt_pkg::IN_DATA_W-1:hmlpt_pkg::KEY_W];
    end
  end

  // Reduce one digit of the key: shift in its bits, subtract the slot count
  always_comb begin
    logic [REM_W-1:0] rem;
    rem = mod_r;
    for (int b = 0; b < hmlpt_pkg::DIGIT_W; b++) begin
      rem = {rem[REM_W-2:0], mod_key_r[hmlpt_pkg::KEY_W-1-b]};
      if (rem >= MOD_N) rem = rem - MOD_N;
    end
    mod_nxt = rem;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_key_r <= in_tdata[hmlpt_pkg::KEY_W-1:0];
      mod_r     <= '0;
      mod_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      mod_key_r <= mod_key_r << hmlpt_pkg::DIGIT_W;
      mod_r     <= mod_nxt;
      mod_cnt_r <= mod_cnt_r + 1'b1;
    end
  end

  assign home = IS_POW2 ? key_r[IDX_W-1:0] : mod_r[IDX_W-1:0];

  // Evaluate the slot whose data is at the memory output
  assign rd         = hmlpt_pkg::slot_t'(ram_rdata);
  assign is_empty   = rd.state == hmlpt_pkg::SLOT_EMPTY;
  assign is_tomb    = rd.state == hmlpt_pkg::SLOT_TOMB;
  assign is_match   = (rd.state == hmlpt_pkg::SLOT_LIVE) && (rd.key == key_r);
  assign last_probe = n_r == LAST_IDX;
  assign done       = is_empty || is_match || last_probe;

  always_comb begin
    pr_match    = 1'b0;
    pr_free     = 1'b0;
    fills_empty = 1'b0;
    where       = rd_idx_r;
    priority if (is_match) begin
      pr_match = 1'b1;
    end else if (is_empty) begin
      pr_free     = 1'b1;
      fills_empty = !have_tomb_r;
      where       = have_tomb_r ? tomb_r : rd_idx_r;
    end else if (have_tomb_r) begin
      pr_free = 1'b1;
      where   = tomb_r;
    end else if (is_tomb) begin
      pr_free = 1'b1;
    end
  end

  assign finish     = cmd.probe_step && done;
  assign need_write = finish &&
                      (((mode_r == hmlpt_pkg::MODE_SET) && (pr_match || pr_free)) ||
                       ((mode_r == hmlpt_pkg::MODE_DEL) && pr_match));

  // Walk the probe sequence: one slot checked and one read per cycle
  always_ff @(posedge clk) begin
    if (cmd.probe_start) begin
      rd_idx_r    <= home;
      idx_r       <= next_idx(home);
      n_r         <= '0;
      have_tomb_r <= 1'b0;
    end else if (cmd.probe_step) begin
      rd_idx_r <= idx_r;
      idx_r    <= next_idx(idx_r);
      n_r      <= n_r + 1'b1;
      if (is_tomb && !have_tomb_r) begin
        have_tomb_r <= 1'b1;
        tomb_r      <= rd_idx_r;
      end
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Memory write: clearing pass or the probe's final update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = where;
    ram_wdata = '0;
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
    end else if (need_write) begin
      ram_we          = 1'b1;
      ram_wdata.state = (mode_r == hmlpt_pkg::MODE_DEL) ? hmlpt_pkg::SLOT_TOMB
                                                         : hmlpt_pkg::SLOT_LIVE;
      ram_wdata.key   = key_r;
      ram_wdata.value = wv_r;
    end
  end

  assign ram_raddr = cmd.probe_start ? home : idx_r;

  hmlpt_ram #(
    .WIDTH (hmlpt_pkg::SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Used count and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_count_r <= '0;
      max_used_r   <= hmlpt_pkg::LIMIT_W'(48);
    end else begin
      if (need_write && (mode_r == hmlpt_pkg::MODE_SET) && pr_free && fills_empty) begin
        used_count_r <= used_count_r + 1'b1;
      end
      if (cfg_valid) begin
        max_used_r <= cfg_data;
      end
    end
  end

  // Result: preset at accept, settled when the probe ends
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_hit_r    <= 1'b0;
      res_val_r    <= '0;
      res_status_r <= quick_status;
    end else if (finish) begin
      unique case (mode_r)
        hmlpt_pkg::MODE_GET: begin
          res_hit_r <= pr_match;
          res_val_r <= pr_match ? rd.value : '0;
        end
        hmlpt_pkg::MODE_SET: begin
          res_hit_r    <= pr_free && !pr_match;
          res_status_r <= !pr_match && !pr_free;
        end
        hmlpt_pkg::MODE_DEL: begin
          res_hit_r <= pr_match;
        end
        default: res_hit_r <= 1'b0;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_hit_r    <= res_hit_r;
      out_val_r    <= res_val_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{hmlpt_pkg::OUT_PAD_W{1'b0}}, out_status_r, out_val_r, out_hit_r};

  // Status to the controller
  assign sts.clear_last = clr_r == LAST_IDX;
  assign sts.quick      = (in_mode == hmlpt_pkg::MODE_UNUSED) || quick_status ||
                          (((in_mode == hmlpt_pkg::MODE_GET) ||
                            (in_mode == hmlpt_pkg::MODE_DEL)) && used_zero);
  assign sts.mod_bypass = IS_POW2;
  assign sts.mod_last   = mod_cnt_r == hmlpt_pkg::DIGIT_CNT_W'(hmlpt_pkg::DIGIT_COUNT - 1);
  assign sts.probe_done = done;
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule
